// File: src/orle_pkg.sv
// orle_pkg: shared types and constants of the ordered ring list engine.
// Used by orle_controller, orle_datapath and ordered_ring_list_engine.
package orle_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned ENTRY_CNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_PAST_END = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    clear;
    logic    init_shift;
    logic    shift_run;
    logic    dec_count;
    logic    init_scan;
    logic    scan_run;
    logic    scan_final;
    logic    emit_simple;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic past_end;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/ordered_ring_list_engine.sv
// ordered_ring_list_engine: top level, controller plus datapath.
// Depends on orle_pkg, orle_controller and orle_datapath.
//
// Usage: one command transaction in (op_i, value_i, position_i) under
// in_valid_i / in_stall_o, one or more result transactions out under
// out_valid_o / out_stall_i. Commands are handled one at a time; in_stall_o
// stays high from acceptance until the last result is loaded into the output
// register, so a new command may be taken while that result still waits.
// Per command:
//   insert, clear, rejected remove: a single result.
//   remove: position 0 counting as 1, each later entry moves down one place
//     per cycle through the entry memory, then a single result.
//   search: one entry compared per cycle while no earlier match waits on a
//     stalled output; one result per match, last_o on the final one, or a
//     single no-match result when nothing matches.
// Reset empties the list at once and drops any pending result; entry memory
// contents are not cleared. While out_stall_i is high the output register
// holds its transaction and a search walk pauses at any further match.
module ordered_ring_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [orle_pkg::VALUE_W-1:0]        value_i,
  input  logic [orle_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic                                match_valid_o,
  output logic [orle_pkg::VALUE_W-1:0]        found_word_o,
  output logic [orle_pkg::ENTRY_CNT_W-1:0]    entry_count_o,
  output logic                                is_empty_o,
  output logic                                last_o
);
  import orle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  orle_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  orle_datapath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .match_valid_o (match_valid_o),
    .found_word_o  (found_word_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("engine not busy after accepting a command");

  a_only_matches_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> match_valid_o && (status_o == ST_DONE))
    else $error("non-final result that is not a search match");

  a_word_zero_without_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_valid_o |-> (found_word_o == '0))
    else $error("found_word set without a match");

  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> !is_empty_o && last_o)
    else $error("full status on an empty list");
`endif

endmodule

// File: src/orle_controller.sv
// orle_controller: sequencing state machine of the ordered ring list engine.
// Depends on orle_pkg; drives orle_datapath through dp_cmd_t / dp_stat_t.
module orle_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  orle_pkg::dp_stat_t stat_i,
  output orle_pkg::dp_cmd_t  cmd_o
);
  import orle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.insert = 1'b1;
              status_d     = ST_DONE;
            end
            state_d = S_RESP;
          end
          OP_REMOVE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else if (stat_i.past_end) begin
              status_d = ST_PAST_END;
              state_d  = S_RESP;
            end else begin
              cmd_o.init_shift = 1'b1;
              state_d          = S_SHIFT;
            end
          end
          OP_SEARCH: begin
            cmd_o.init_scan = 1'b1;
            state_d         = S_SCAN;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            status_d    = ST_DONE;
            state_d     = S_RESP;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.shift_run = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.dec_count = 1'b1;
          status_d        = ST_DONE;
          state_d         = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.walk_done && stat_i.out_free) begin
          cmd_o.scan_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_simple = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.status = status_q;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: src/orle_datapath.sv
// orle_datapath: entry memory, count, walk pointer and output register.
// Depends on orle_pkg; commanded by orle_controller.
module orle_datapath #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  orle_pkg::dp_cmd_t                   cmd_i,
  output orle_pkg::dp_stat_t                  stat_o,
  input  logic [1:0]                          op_i,
  input  logic [orle_pkg::VALUE_W-1:0]        value_i,
  input  logic [orle_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic                                match_valid_o,
  output logic [orle_pkg::VALUE_W-1:0]        found_word_o,
  output logic [orle_pkg::ENTRY_CNT_W-1:0]    entry_count_o,
  output logic                                is_empty_o,
  output logic                                last_o
);
  import orle_pkg::*;

  localparam int unsigned SW = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [SW-1:0] mem [CAPACITY];

  op_e              op_q;
  logic [SW-1:0]    key_q;
  logic [POS_W-1:0] pos_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    rd_idx_q;
  logic [AW-1:0]    cmp_idx_q;
  logic             rd_vld_q;
  logic [SW-1:0]    rd_data_q;
  logic [SW-1:0]    held_q;
  logic             held_vld_q;

  logic             out_valid_q;
  status_e          out_status_q;
  logic             out_match_q;
  logic [SW-1:0]    out_word_q;
  logic [ENTRY_CNT_W-1:0] out_count_q;
  logic             out_empty_q;
  logic             out_last_q;

  logic [POS_W-1:0] rem_idx;
  logic             out_free;
  logic             more;
  logic             hit;
  logic             push;
  logic             proceed;
  logic             step;
  logic             rd_en;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SW-1:0]    mem_wdata;
  logic             emit;
  status_e          emit_status;
  logic             emit_match;
  logic [SW-1:0]    emit_word;
  logic             emit_last;

  assign rem_idx  = (pos_q == '0) ? '0 : pos_q - POS_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign more     = rd_idx_q < count_q;
  assign hit      = rd_vld_q && (rd_data_q == key_q);
  assign push     = hit && held_vld_q;
  assign proceed  = cmd_i.scan_run && (!push || out_free);
  assign step     = proceed || cmd_i.shift_run;
  assign rd_en    = step && more;

  assign mem_we    = cmd_i.insert || (cmd_i.shift_run && rd_vld_q);
  assign mem_waddr = cmd_i.insert ? count_q[AW-1:0] : cmp_idx_q - AW'(1);
  assign mem_wdata = cmd_i.insert ? key_q : rd_data_q;

  assign stat_o.op        = op_q;
  assign stat_o.full      = (count_q == CAP_CNT);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.past_end  = XW'(rem_idx) >= XW'(count_q);
  assign stat_o.walk_done = !rd_vld_q && !more;
  assign stat_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx_q[AW-1:0]];
      cmp_idx_q <= rd_idx_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      key_q <= value_i[SW-1:0];
      pos_q <= position_i;
    end
    if (cmd_i.init_shift) begin
      rd_idx_q <= CW'(rem_idx) + CW'(1);
    end else if (cmd_i.init_scan) begin
      rd_idx_q <= '0;
    end else if (rd_en) begin
      rd_idx_q <= rd_idx_q + CW'(1);
    end
    if (proceed && hit) begin
      held_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_vld_q   <= 1'b0;
      held_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.insert) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.init_shift || cmd_i.init_scan) begin
        rd_vld_q <= 1'b0;
      end else if (step) begin
        rd_vld_q <= more;
      end
      if (cmd_i.init_scan) begin
        held_vld_q <= 1'b0;
      end else if (proceed && hit) begin
        held_vld_q <= 1'b1;
      end
    end
  end

  // result selection: plain reply, pushed-out earlier match, or end of search
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_DONE;
    emit_match  = 1'b0;
    emit_word   = '0;
    emit_last   = 1'b1;
    if (cmd_i.emit_simple) begin
      emit        = 1'b1;
      emit_status = cmd_i.status;
    end else if (proceed && push) begin
      emit       = 1'b1;
      emit_match = 1'b1;
      emit_word  = held_q;
      emit_last  = 1'b0;
    end else if (cmd_i.scan_final) begin
      emit = 1'b1;
      if (held_vld_q) begin
        emit_match = 1'b1;
        emit_word  = held_q;
      end else if (count_q == '0) begin
        emit_status = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= emit_status;
      out_match_q  <= emit_match;
      out_word_q   <= emit_word;
      out_count_q  <= ENTRY_CNT_W'(count_q);
      out_empty_q  <= (count_q == '0);
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign match_valid_o = out_match_q;
  assign found_word_o  = VALUE_W'(out_word_q);
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign last_o        = out_last_q;

endmodule
